// ===== hw/rtl/ctus_pkg.sv =====
// shared types, constants and helper functions for the civil time to unix seconds core
`default_nettype none

package ctus_pkg;

   localparam int unsigned YEAR_W      = 14;
   localparam int unsigned FIELD_W     = 7;
   localparam int unsigned DOY_W       = 9;
   localparam int unsigned TOD_W       = 19;
   localparam int unsigned DAYS_W      = 24;
   localparam int unsigned SECS_W      = 32;

   // shift the year so the march-based year stays positive
   localparam int unsigned YEAR_BIAS   = 400;
   // days to 1970-01-01 from year zero plus the 400 year shift plus the day-one offset
   localparam int unsigned DAY_BIAS    = 865566;
   localparam int unsigned SEC_PER_DAY = 86400;
   localparam int unsigned SEC_PER_HR  = 3600;
   localparam int unsigned SEC_PER_MIN = 60;
   // floor(x / 25) = (x * 5243) >> 17 for x below 43690
   localparam int unsigned DIV25_MUL   = 5243;
   localparam int unsigned DIV25_SHIFT = 17;

   typedef struct packed {
      logic [15:0] year_bcd;
      logic [7:0]  month_bcd;
      logic [7:0]  day_bcd;
      logic [7:0]  hour_bcd;
      logic [7:0]  minute_bcd;
      logic [7:0]  second_bcd;
   } ctus_req_type;

   typedef struct packed {
      logic [31:0] unix_seconds;
      logic        bad_digit;
   } ctus_rsp_type;

   // decoded binary fields
   typedef struct packed {
      logic               bad;
      logic [YEAR_W-1:0]  year;
      logic [FIELD_W-1:0] month;
      logic [FIELD_W-1:0] day;
      logic [FIELD_W-1:0] hour;
      logic [FIELD_W-1:0] minute;
      logic [FIELD_W-1:0] second;
   } ctus_dec_type;

   // day count and time of day
   typedef struct packed {
      logic                     bad;
      logic signed [DAYS_W-1:0] days;
      logic [TOD_W-1:0]         tod;
   } ctus_days_type;

   // month carry folded with the march-based year shift
   typedef struct packed {
      logic signed [4:0] year_adj;
      logic [DOY_W-1:0]  doy_base;
   } ctus_mon_type;

   function automatic logic nib_bad(input logic [3:0] nib);
      return nib > 4'd9;
   endfunction

   function automatic logic [FIELD_W-1:0] bcd2_value(input logic [7:0] v);
      return FIELD_W'(8'(v[7:4]) * 8'd10 + 8'(v[3:0]));
   endfunction

   function automatic logic [YEAR_W-1:0] bcd4_value(input logic [15:0] v);
      return YEAR_W'(16'(v[15:12]) * 16'd1000 + 16'(v[11:8]) * 16'd100
                   + 16'(v[7:4]) * 16'd10 + 16'(v[3:0]));
   endfunction

   // month 0..99 -> year adjustment and day of march-based year of the 1st
   function automatic ctus_mon_type mon_norm(input logic [FIELD_W-1:0] mon);
      ctus_mon_type r;
      logic [3:0]   carry;
      logic [6:0]   mi_wide;
      logic [3:0]   mi;
      carry = 4'd0;
      for (int k = 1; k <= 8; k++) begin
         if (mon >= 7'(12 * k + 1)) begin
            carry = carry + 4'd1;
         end
      end
      mi_wide = mon - 7'd1 - 7'(carry) * 7'd12;
      mi      = mi_wide[3:0];
      if (mon == '0) begin
         mi = 4'd11;
      end
      r.year_adj = (mon == '0) ? -5'sd1 : $signed({1'b0, carry});
      if (mi < 4'd2) begin
         r.year_adj = r.year_adj - 5'sd1;
      end
      case (mi)
         4'd0:    r.doy_base = 9'd306;
         4'd1:    r.doy_base = 9'd337;
         4'd2:    r.doy_base = 9'd0;
         4'd3:    r.doy_base = 9'd31;
         4'd4:    r.doy_base = 9'd61;
         4'd5:    r.doy_base = 9'd92;
         4'd6:    r.doy_base = 9'd122;
         4'd7:    r.doy_base = 9'd153;
         4'd8:    r.doy_base = 9'd184;
         4'd9:    r.doy_base = 9'd214;
         4'd10:   r.doy_base = 9'd245;
         4'd11:   r.doy_base = 9'd275;
         default: r.doy_base = 9'd0;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/ctus_decode.sv =====
// bcd decode stage with digit check
`default_nettype none

module ctus_decode (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  in_valid,
   output logic                       in_ready,
   input  wire ctus_pkg::ctus_req_type in_data,
   output logic                       out_valid,
   input  wire logic                  out_ready,
   output ctus_pkg::ctus_dec_type     out_data
);
   import ctus_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   ctus_dec_type data_ff;
   ctus_dec_type data_in;
   logic         en;

   assign en       = !valid_ff || out_ready;
   assign in_ready = en;
   assign valid_in = en ? in_valid : valid_ff;

   always_comb begin
      data_in.bad = nib_bad(in_data.year_bcd[15:12]) || nib_bad(in_data.year_bcd[11:8])
                 || nib_bad(in_data.year_bcd[7:4])   || nib_bad(in_data.year_bcd[3:0])
                 || nib_bad(in_data.month_bcd[7:4])  || nib_bad(in_data.month_bcd[3:0])
                 || nib_bad(in_data.day_bcd[7:4])    || nib_bad(in_data.day_bcd[3:0])
                 || nib_bad(in_data.hour_bcd[7:4])   || nib_bad(in_data.hour_bcd[3:0])
                 || nib_bad(in_data.minute_bcd[7:4]) || nib_bad(in_data.minute_bcd[3:0])
                 || nib_bad(in_data.second_bcd[7:4]) || nib_bad(in_data.second_bcd[3:0]);
      data_in.year   = bcd4_value(in_data.year_bcd);
      data_in.month  = bcd2_value(in_data.month_bcd);
      data_in.day    = bcd2_value(in_data.day_bcd);
      data_in.hour   = bcd2_value(in_data.hour_bcd);
      data_in.minute = bcd2_value(in_data.minute_bcd);
      data_in.second = bcd2_value(in_data.second_bcd);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/ctus_calendar.sv =====
// three-stage days-from-civil pipeline with time of day
`default_nettype none

module ctus_calendar (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  in_valid,
   output logic                       in_ready,
   input  wire ctus_pkg::ctus_dec_type in_data,
   output logic                       out_valid,
   input  wire logic                  out_ready,
   output ctus_pkg::ctus_days_type    out_data
);
   import ctus_pkg::*;

   typedef struct packed {
      logic               bad;
      logic [YEAR_W-1:0]  yr;
      logic [DOY_W-1:0]   dayoff;
      logic [TOD_W-1:0]   tod;
   } norm_type;

   typedef struct packed {
      logic               bad;
      logic [21:0]        y365;
      logic [11:0]        y4;
      logic [6:0]         q100;
      logic [4:0]         q400;
      logic [DOY_W-1:0]   dayoff;
      logic [TOD_W-1:0]   tod;
   } parts_type;

   logic          v2_ff, v3_ff, v4_ff;
   logic          en2, en3, en4;
   norm_type      s2_ff, s2_in;
   parts_type     s3_ff, s3_in;
   ctus_days_type s4_ff, s4_in;
   ctus_mon_type  mon;
   logic [15:0]   yr_wide;
   logic [23:0]   p100;
   logic [21:0]   p400;

   assign en4      = !v4_ff || out_ready;
   assign en3      = !v3_ff || en4;
   assign en2      = !v2_ff || en3;
   assign in_ready = en2;

   // month carry, march-based year and time of day
   always_comb begin
      mon          = mon_norm(in_data.month);
      yr_wide      = 16'(in_data.year) + 16'(YEAR_BIAS) + {{11{mon.year_adj[4]}}, mon.year_adj};
      s2_in.bad    = in_data.bad;
      s2_in.yr     = yr_wide[YEAR_W-1:0];
      s2_in.dayoff = DOY_W'(in_data.day) + mon.doy_base;
      s2_in.tod    = TOD_W'(in_data.hour) * TOD_W'(SEC_PER_HR)
                   + TOD_W'(in_data.minute) * TOD_W'(SEC_PER_MIN)
                   + TOD_W'(in_data.second);
   end

   // year length terms, leap corrections through reciprocal multiply
   always_comb begin
      p100         = 24'(s2_ff.yr[YEAR_W-1:2]) * 24'(DIV25_MUL);
      p400         = 22'(s2_ff.yr[YEAR_W-1:4]) * 22'(DIV25_MUL);
      s3_in.bad    = s2_ff.bad;
      s3_in.y365   = 22'(s2_ff.yr) * 22'd365;
      s3_in.y4     = s2_ff.yr[YEAR_W-1:2];
      s3_in.q100   = p100[DIV25_SHIFT+6:DIV25_SHIFT];
      s3_in.q400   = p400[DIV25_SHIFT+4:DIV25_SHIFT];
      s3_in.dayoff = s2_ff.dayoff;
      s3_in.tod    = s2_ff.tod;
   end

   // day count relative to the epoch
   always_comb begin
      s4_in.bad  = s3_ff.bad;
      s4_in.days = $signed(24'(s3_ff.y365) + 24'(s3_ff.y4) - 24'(s3_ff.q100)
                 + 24'(s3_ff.q400) + 24'(s3_ff.dayoff) - 24'(DAY_BIAS));
      s4_in.tod  = s3_ff.tod;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (en2) v2_ff <= in_valid;
         if (en3) v3_ff <= v2_ff;
         if (en4) v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en2 && in_valid) s2_ff <= s2_in;
      if (en3 && v2_ff)    s3_ff <= s3_in;
      if (en4 && v3_ff)    s4_ff <= s4_in;
   end

   assign out_valid = v4_ff;
   assign out_data  = s4_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/ctus_scale.sv =====
// day count to seconds, output register
`default_nettype none

module ctus_scale (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   in_valid,
   output logic                        in_ready,
   input  wire ctus_pkg::ctus_days_type in_data,
   output logic                        out_valid,
   input  wire logic                   out_ready,
   output ctus_pkg::ctus_rsp_type      out_data
);
   import ctus_pkg::*;

   logic                valid_ff;
   ctus_rsp_type        data_ff;
   ctus_rsp_type        data_in;
   logic [SECS_W-1:0]   days_ext;
   logic                en;

   assign en       = !valid_ff || out_ready;
   assign in_ready = en;
   assign days_ext = SECS_W'(in_data.days);

   always_comb begin
      data_in.bad_digit    = in_data.bad;
      data_in.unix_seconds = in_data.bad ? '0
                           : days_ext * SECS_W'(SEC_PER_DAY) + SECS_W'(in_data.tod);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/civil_time_to_unix_seconds_core.sv =====
// top level of the civil time to unix seconds converter
`default_nettype none

// converts a bcd timestamp yyyymmddhhmmss into seconds since 1970-01-01 utc,
// wrapped to 32 bits. the month carries into the year (month 00 is december
// of the year before, 13 and up roll forward); day, hour, minute and second
// are added linearly so out-of-range values spill into later units. any
// nibble above nine sets bad_digit and forces unix_seconds to zero.
// throughput is one item per clock while rsp_ready is high; each item passes
// through bcd decode, month normalization and time of day, year terms with
// reciprocal-multiply leap corrections, day count, and the final multiply
// by 86400 into the output register. every stage has its own valid bit and
// advances whenever the stage after it is empty or moving, so bubbles close
// up and a stalled rsp side backs up without loss.

module civil_time_to_unix_seconds_core (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // request channel
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire ctus_pkg::ctus_req_type req_data,
   // result channel
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output ctus_pkg::ctus_rsp_type     rsp_data
);
   import ctus_pkg::*;

   // decode to calendar
   logic          dec_valid;
   logic          dec_ready;
   ctus_dec_type  dec_data;

   // calendar to scaling
   logic          days_valid;
   logic          days_ready;
   ctus_days_type days_data;

   // stage 1: bcd to binary, digit check
   ctus_decode u_decode (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_data   (req_data),
      .out_valid (dec_valid),
      .out_ready (dec_ready),
      .out_data  (dec_data)
   );

   // stages 2 to 4: days since epoch
   ctus_calendar u_calendar (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (dec_valid),
      .in_ready  (dec_ready),
      .in_data   (dec_data),
      .out_valid (days_valid),
      .out_ready (days_ready),
      .out_data  (days_data)
   );

   // stage 5: seconds, result register
   ctus_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (days_valid),
      .in_ready  (days_ready),
      .in_data   (days_data),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_data)
   );

endmodule

`default_nettype wire

// ===== tb/unix_seconds_checker.sv =====
// checker that predicts and compares unix seconds results for the bcd timestamp converter
module unix_seconds_checker (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  ctus_pkg::ctus_req_type req_data,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  ctus_pkg::ctus_rsp_type rsp_data,
   output int                    fail_count,
   output int                    pending_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import ctus_pkg::*;

   ctus_rsp_type expected_stamps[$];
   ctus_rsp_type want;

   function automatic longint bcd_digits(input logic [15:0] v, input int n);
      longint acc;
      acc = 0;
      for (int k = n - 1; k >= 0; k--) begin
         acc = acc * 10 + longint'(v[4*k +: 4]);
      end
      return acc;
   endfunction

   // seconds since the epoch with timegm style month carry and linear spill
   function automatic ctus_rsp_type civil_to_unix(input ctus_req_type stamp);
      ctus_rsp_type res;
      logic [55:0]  nibbles;
      logic         bad;
      longint       yr, mo, dy, hr, mn, sc;
      longint       mon0, carry, y, m, era, yoe, doy, doe, days, total;
      nibbles = stamp;
      bad = 1'b0;
      for (int k = 0; k < 14; k++) begin
         if (nibbles[4*k +: 4] > 4'd9) begin
            bad = 1'b1;
         end
      end
      res.unix_seconds = '0;
      res.bad_digit    = bad;
      if (bad) begin
         return res;
      end
      yr = bcd_digits(stamp.year_bcd, 4);
      mo = bcd_digits(16'(stamp.month_bcd), 2);
      dy = bcd_digits(16'(stamp.day_bcd), 2);
      hr = bcd_digits(16'(stamp.hour_bcd), 2);
      mn = bcd_digits(16'(stamp.minute_bcd), 2);
      sc = bcd_digits(16'(stamp.second_bcd), 2);
      // month zero borrows a year, months past twelve carry forward
      mon0  = mo - 1;
      carry = (mon0 >= 0) ? mon0 / 12 : -((11 - mon0) / 12);
      mon0  = mon0 - carry * 12;
      y     = yr + carry;
      m     = mon0 + 1;
      // march-based year, 400 year eras
      if (m <= 2) begin
         y = y - 1;
      end
      era  = ((y >= 0) ? y : y - 399) / 400;
      yoe  = y - era * 400;
      doy  = (153 * ((m > 2) ? m - 3 : m + 9) + 2) / 5;
      doe  = yoe * 365 + yoe / 4 - yoe / 100 + doy;
      days = era * 146097 + doe - 719468 + (dy - 1);
      total = days * 86400 + hr * 3600 + mn * 60 + sc;
      res.unix_seconds = total[31:0];
      return res;
   endfunction

   task automatic report_mismatch(input string what);
      $display("%0t mismatch: %s", $time, what);
      fail_count++;
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            expected_stamps.push_back(civil_to_unix(req_data));
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_stamps.size() == 0) begin
               report_mismatch($sformatf("result %0h/%0b with no timestamp pending",
                                         rsp_data.unix_seconds, rsp_data.bad_digit));
            end else begin
               want = expected_stamps.pop_front();
               if (rsp_data.unix_seconds !== want.unix_seconds) begin
                  report_mismatch($sformatf("unix_seconds got %0h want %0h",
                                            rsp_data.unix_seconds, want.unix_seconds));
               end
               if (rsp_data.bad_digit !== want.bad_digit) begin
                  report_mismatch($sformatf("bad_digit got %0b want %0b",
                                            rsp_data.bad_digit, want.bad_digit));
               end
            end
         end
      end
      pending_count <= expected_stamps.size();
   end

endmodule

// ===== tb/civil_time_to_unix_seconds_core_tb.sv =====
// top of the bench for the bcd timestamp to unix seconds converter
module civil_time_to_unix_seconds_core_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import ctus_pkg::*;

   // run ends here no matter what
   localparam int CYCLE_LIMIT  = 200000;
   localparam int RANDOM_ITEMS = 430;
   // cycles to keep watching after the last result, well past the pipeline depth
   localparam int DRAIN_CYCLES = 12;

   logic         clock     = 1'b0;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   ctus_req_type req_data  = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   ctus_rsp_type rsp_data;

   // when set neither side idles
   logic         steady    = 1'b0;
   int           cycle_count = 0;
   int           fail_count;
   int           pending_count;

   ctus_req_type directed_stamps[$];

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   civil_time_to_unix_seconds_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   unix_seconds_checker checker_inst (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_data      (rsp_data),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   // decimal value to packed bcd, four digits
   function automatic logic [15:0] to_bcd(input int v);
      logic [15:0] r;
      for (int k = 0; k < 4; k++) begin
         r[4*k +: 4] = 4'(v % 10);
         v = v / 10;
      end
      return r;
   endfunction

   function automatic ctus_req_type make_stamp(input int y, input int mo, input int d,
                                               input int h, input int mi, input int s);
      ctus_req_type stamp;
      stamp.year_bcd   = to_bcd(y);
      stamp.month_bcd  = 8'(to_bcd(mo));
      stamp.day_bcd    = 8'(to_bcd(d));
      stamp.hour_bcd   = 8'(to_bcd(h));
      stamp.minute_bcd = 8'(to_bcd(mi));
      stamp.second_bcd = 8'(to_bcd(s));
      return stamp;
   endfunction

   // mostly well-formed timestamps with random content, some raw noise,
   // some with a single non-decimal nibble planted
   function automatic ctus_req_type random_stamp();
      ctus_req_type stamp;
      logic [55:0]  bits;
      int           pick;
      int           y, mo, d, h, mi, s;
      pick = $urandom_range(99);
      if (pick < 10) begin
         bits = 56'({$urandom, $urandom});
         stamp = bits[55:0];
         return stamp;
      end
      y  = ($urandom_range(99) < 60) ? $urandom_range(2200, 1900) : $urandom_range(9999);
      mo = ($urandom_range(99) < 85) ? $urandom_range(12, 1) : $urandom_range(99);
      d  = ($urandom_range(99) < 85) ? $urandom_range(31, 1) : $urandom_range(99);
      h  = ($urandom_range(99) < 85) ? $urandom_range(23) : $urandom_range(99);
      mi = ($urandom_range(99) < 85) ? $urandom_range(59) : $urandom_range(99);
      s  = ($urandom_range(99) < 85) ? $urandom_range(59) : $urandom_range(99);
      stamp = make_stamp(y, mo, d, h, mi, s);
      if (pick < 16) begin
         bits = stamp;
         bits[4*$urandom_range(13) +: 4] = 4'($urandom_range(15, 10));
         stamp = bits;
      end
      return stamp;
   endfunction

   // present one item and hold it until the block takes it; random idle
   // cycles go in front unless the steady stretch is on
   task automatic send_stamp(input ctus_req_type stamp);
      while (!steady && $urandom_range(99) < 18) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= stamp;
      do @(posedge clock); while (!req_ready);
   endtask

   // result side stalls at the same rate
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= steady || ($urandom_range(99) >= 18);
      end
   end

   // hard stop on a hung pipeline
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      ctus_req_type odd;

      // plain dates, the epoch itself and the ends of the year range
      directed_stamps.push_back(make_stamp(1970, 1, 1, 0, 0, 0));
      directed_stamps.push_back(make_stamp(0, 1, 1, 0, 0, 0));
      directed_stamps.push_back(make_stamp(9999, 12, 31, 23, 59, 59));
      // every two digit field at its decimal maximum
      directed_stamps.push_back(make_stamp(9999, 99, 99, 99, 99, 99));
      // all zero: month zero borrows into year -1, day zero steps back a day
      directed_stamps.push_back(make_stamp(0, 0, 0, 0, 0, 0));
      // month zero is december of the year before
      directed_stamps.push_back(make_stamp(2024, 0, 15, 12, 0, 0));
      // months past twelve roll into later years
      directed_stamps.push_back(make_stamp(2023, 13, 1, 0, 0, 0));
      directed_stamps.push_back(make_stamp(2023, 99, 1, 0, 0, 0));
      // day zero is the last day of the month before, here a leap february
      directed_stamps.push_back(make_stamp(2000, 3, 0, 0, 0, 0));
      // time of day fields overflowing into the next day
      directed_stamps.push_back(make_stamp(2021, 6, 15, 99, 99, 99));
      // one second before the epoch wraps to all ones
      directed_stamps.push_back(make_stamp(1969, 12, 31, 23, 59, 59));
      // signed 32 bit rollover and the unsigned wrap back to zero
      directed_stamps.push_back(make_stamp(2038, 1, 19, 3, 14, 8));
      directed_stamps.push_back(make_stamp(2106, 2, 7, 6, 28, 16));
      // leap rules: 400 year, century non-leap spill, far future leap year, 1600
      directed_stamps.push_back(make_stamp(2000, 2, 29, 0, 0, 0));
      directed_stamps.push_back(make_stamp(1900, 2, 29, 0, 0, 0));
      directed_stamps.push_back(make_stamp(2400, 2, 29, 12, 0, 0));
      directed_stamps.push_back(make_stamp(1600, 1, 1, 0, 0, 0));
      // non-decimal nibbles, one field at a time, then every bit set
      odd = make_stamp(2024, 5, 5, 5, 5, 5);
      odd.year_bcd = 16'h200A;
      directed_stamps.push_back(odd);
      odd = make_stamp(2024, 5, 5, 5, 5, 5);
      odd.month_bcd = 8'hA1;
      directed_stamps.push_back(odd);
      odd = make_stamp(2024, 5, 5, 5, 5, 5);
      odd.day_bcd = 8'h3B;
      directed_stamps.push_back(odd);
      odd = make_stamp(2024, 5, 5, 5, 5, 5);
      odd.hour_bcd = 8'hF0;
      directed_stamps.push_back(odd);
      odd = make_stamp(2024, 5, 5, 5, 5, 5);
      odd.minute_bcd = 8'h7C;
      directed_stamps.push_back(odd);
      odd = make_stamp(2024, 5, 5, 5, 5, 5);
      odd.second_bcd = 8'h5F;
      directed_stamps.push_back(odd);
      directed_stamps.push_back('1);

      // hold synchronous reset, then release it
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_stamps[i]) begin
         send_stamp(directed_stamps[i]);
      end

      // random part with a stretch in the middle where nobody idles
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == 150) begin
            steady <= 1'b1;
         end
         if (n == 260) begin
            steady <= 1'b0;
         end
         send_stamp(random_stamp());
      end
      req_valid <= 1'b0;

      // wait for every predicted result, then watch for strays
      do @(posedge clock); while (pending_count != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);

      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
hw/rtl/ctus_pkg.sv
hw/rtl/ctus_decode.sv
hw/rtl/ctus_calendar.sv
hw/rtl/ctus_scale.sv
hw/rtl/civil_time_to_unix_seconds_core.sv
tb/unix_seconds_checker.sv
tb/civil_time_to_unix_seconds_core_tb.sv
